FILE: rtl/hlva_pkg.sv
package hlva_pkg;

    // Field widths of one input beat and one result beat
    localparam int OPCODE_W   = 2;
    localparam int PIXEL_X_W  = 10;
    localparam int PIXEL_Y_W  = 9;
    localparam int PIXEL_V_W  = 8;
    localparam int ANGLE_IDX_W = 8;
    localparam int DIST_IDX_W = 11;
    localparam int COUNT_W    = 16;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_VOTE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [PIXEL_V_W-1:0] VOTE_PIXEL      = 8'd255;
    localparam logic [COUNT_W-1:0]   THRESHOLD_RESET = 16'd150;
    localparam logic [COUNT_W-1:0]   COUNT_MAX       = 16'hFFFF;

    // Q1.14 trig and rounding
    localparam int Q_FRAC        = 14;
    localparam int Q_HALF        = 8192;
    localparam int DEG_HALF_TURN = 180;
    localparam int DEG_QUARTER   = 90;

    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode;
        logic [PIXEL_X_W-1:0]   pixel_x;
        logic [PIXEL_Y_W-1:0]   pixel_y;
        logic [PIXEL_V_W-1:0]   pixel_value;
        logic [ANGLE_IDX_W-1:0] angle_index;
        logic [DIST_IDX_W-1:0]  distance_index;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] vote_count;
        logic               is_peak;
    } t_out_item;

    // round(16384 * sin(d degrees)), d = 0..90
    localparam logic signed [15:0] SIN_Q14 [91] = '{
            16'sd0,     16'sd286,   16'sd572,   16'sd857,   16'sd1143,
            16'sd1428,  16'sd1713,  16'sd1997,  16'sd2280,  16'sd2563,
            16'sd2845,  16'sd3126,  16'sd3406,  16'sd3686,  16'sd3964,
            16'sd4240,  16'sd4516,  16'sd4790,  16'sd5063,  16'sd5334,
            16'sd5604,  16'sd5872,  16'sd6138,  16'sd6402,  16'sd6664,
            16'sd6924,  16'sd7182,  16'sd7438,  16'sd7692,  16'sd7943,
            16'sd8192,  16'sd8438,  16'sd8682,  16'sd8923,  16'sd9162,
            16'sd9397,  16'sd9630,  16'sd9860,  16'sd10087, 16'sd10311,
            16'sd10531, 16'sd10749, 16'sd10963, 16'sd11174, 16'sd11381,
            16'sd11585, 16'sd11786, 16'sd11982, 16'sd12176, 16'sd12365,
            16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085, 16'sd13255,
            16'sd13421, 16'sd13583, 16'sd13741, 16'sd13894, 16'sd14044,
            16'sd14189, 16'sd14330, 16'sd14466, 16'sd14598, 16'sd14726,
            16'sd14849, 16'sd14968, 16'sd15082, 16'sd15191, 16'sd15296,
            16'sd15396, 16'sd15491, 16'sd15582, 16'sd15668, 16'sd15749,
            16'sd15826, 16'sd15897, 16'sd15964, 16'sd16026, 16'sd16083,
            16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262, 16'sd16294,
            16'sd16322, 16'sd16344, 16'sd16362, 16'sd16374, 16'sd16382,
            16'sd16384
    };

    function automatic logic signed [15:0] sin_q14(input logic [6:0] deg);
        logic signed [15:0] val;
        val = 16'sd0;
        if (deg <= 7'(DEG_QUARTER)) begin
            val = SIN_Q14[deg];
        end
        return val;
    endfunction

endpackage

FILE: rtl/hlva_ram.sv
module hlva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 288180,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/hlva_rho_unit.sv
module hlva_rho_unit
    import hlva_pkg::*;
#(
    parameter int ANGLE_BINS   = 180,
    parameter int MAX_DISTANCE = 800
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    input  logic [$clog2(ANGLE_BINS)-1:0]                  i_angle,
    input  logic [7:0]                                     i_deg,
    input  logic [PIXEL_X_W-1:0]                           i_x,
    input  logic [PIXEL_Y_W-1:0]                           i_y,
    output logic                                           o_valid,
    output logic [$clog2(ANGLE_BINS*(2*MAX_DISTANCE+1))-1:0] o_addr,
    output logic                                           o_busy
);

    localparam int RHO_BINS = 2 * MAX_DISTANCE + 1;
    localparam int DEPTH    = ANGLE_BINS * RHO_BINS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ANG_W    = $clog2(ANGLE_BINS);
    localparam int RHO_W    = $clog2(RHO_BINS);
    localparam int P_W      = 27;
    localparam int V_W      = 28;
    localparam int M_W      = 29;
    localparam int Q_W      = M_W - Q_FRAC;
    localparam int N_W      = 18;

    // stage 1: table lookup
    logic                    r1_valid;
    logic [ANG_W-1:0]        r1_m;
    logic signed [15:0]      r1_cos;
    logic signed [15:0]      r1_sin;
    // stage 2: products
    logic                    r2_valid;
    logic [ANG_W-1:0]        r2_m;
    logic signed [P_W-1:0]   r2_px;
    logic signed [P_W-1:0]   r2_py;
    // stage 3: sum
    logic                    r3_valid;
    logic [ANG_W-1:0]        r3_m;
    logic signed [V_W-1:0]   r3_v;
    // stage 4: magnitude plus half
    logic                    r4_valid;
    logic [ANG_W-1:0]        r4_m;
    logic                    r4_neg;
    logic [M_W-1:0]          r4_mag;
    // stage 5: distance bin
    logic                    r5_valid;
    logic [ANG_W-1:0]        r5_m;
    logic [RHO_W-1:0]        r5_rho;
    // stage 6: address
    logic                    r6_valid;
    logic [ADDR_W-1:0]       r6_addr;

    logic signed [15:0]      n_cos;
    logic signed [15:0]      n_sin;
    logic signed [M_W-1:0]   n_v_ext;
    logic [Q_W-1:0]          n_q;
    logic [N_W-1:0]          n_rho;
    logic                    n_in_range;

    always_comb begin
        if (i_deg <= 8'(DEG_QUARTER)) begin
            n_cos = sin_q14(7'(8'(DEG_QUARTER) - i_deg));
            n_sin = sin_q14(7'(i_deg));
        end else begin
            n_cos = -sin_q14(7'(i_deg - 8'(DEG_QUARTER)));
            n_sin = sin_q14(7'(8'(DEG_HALF_TURN) - i_deg));
        end
    end

    assign n_v_ext    = M_W'(r3_v);
    assign n_q        = Q_W'(r4_mag >> Q_FRAC);
    assign n_rho      = r4_neg ? (N_W'(MAX_DISTANCE) - N_W'(n_q))
                               : (N_W'(MAX_DISTANCE) + N_W'(n_q));
    assign n_in_range = !n_rho[N_W-1] && (n_rho < N_W'(RHO_BINS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid && n_in_range;
            r6_valid <= r5_valid;
        end
        r1_m    <= i_angle;
        r1_cos  <= n_cos;
        r1_sin  <= n_sin;
        r2_m    <= r1_m;
        r2_px   <= P_W'($signed({1'b0, i_x}) * r1_cos);
        r2_py   <= P_W'($signed({1'b0, i_y}) * r1_sin);
        r3_m    <= r2_m;
        r3_v    <= V_W'(r2_px) + V_W'(r2_py);
        r4_m    <= r3_m;
        r4_neg  <= r3_v[V_W-1];
        // round half away from zero: |v| + half, then shift
        r4_mag  <= r3_v[V_W-1] ? M_W'(M_W'(Q_HALF) - n_v_ext)
                               : M_W'(n_v_ext + M_W'(Q_HALF));
        r5_m    <= r4_m;
        r5_rho  <= n_rho[RHO_W-1:0];
        r6_addr <= ADDR_W'(32'(r5_rho) * ANGLE_BINS + 32'(r5_m));
    end

    assign o_valid = r6_valid;
    assign o_addr  = r6_addr;
    assign o_busy  = r1_valid || r2_valid || r3_valid || r4_valid || r5_valid || r6_valid;

endmodule

FILE: rtl/hough_line_vote_accumulator_core.sv
// Vote: one angle per cycle through the shared rho pipeline and a read-modify-write
//   RAM port; the result beat follows once the last write-back has landed.
// Query: nine reads for an inner bin, one for a border bin; dropped items read none.
// Clear: ANGLE_BINS*(2*MAX_DISTANCE+1) bins (288180 at defaults), one bin a cycle.
// Reset: synchronous, active low; afterwards a clearing pass (one bin a cycle) zeroes
//   the vote store with o_in_ready low; threshold resets to 150.
module hough_line_vote_accumulator_core
    import hlva_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480,
    parameter int ANGLE_BINS   = 180,
    parameter int MAX_DISTANCE = 800
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int RHO_BINS = 2 * MAX_DISTANCE + 1;
    localparam int DEPTH    = ANGLE_BINS * RHO_BINS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ANG_W    = $clog2(ANGLE_BINS);
    localparam int ACC_W    = $clog2(ANGLE_BINS) + 1;
    localparam int DEG_STEP = DEG_HALF_TURN / ANGLE_BINS;
    localparam int DEG_REM  = DEG_HALF_TURN % ANGLE_BINS;

    // Neighbor read order of a query: center first, then the eight around it
    localparam logic [3:0] RD_CENTER = 4'd0;
    localparam logic [3:0] RD_NW     = 4'd1;
    localparam logic [3:0] RD_N      = 4'd2;
    localparam logic [3:0] RD_NE     = 4'd3;
    localparam logic [3:0] RD_W      = 4'd4;
    localparam logic [3:0] RD_E      = 4'd5;
    localparam logic [3:0] RD_SW     = 4'd6;
    localparam logic [3:0] RD_S      = 4'd7;
    localparam logic [3:0] RD_SE     = 4'd8;

    localparam logic [ADDR_W-1:0] STEP_1   = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] STEP_A   = ADDR_W'(ANGLE_BINS);
    localparam logic [ADDR_W-1:0] STEP_AM1 = ADDR_W'(ANGLE_BINS - 1);
    localparam logic [ADDR_W-1:0] STEP_AP1 = ADDR_W'(ANGLE_BINS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_VOTE,
        S_DRAIN,
        S_QBASE,
        S_QREAD,
        S_QWAIT,
        S_RESULT
    } t_state;

    t_state                   r_state;
    logic [COUNT_W-1:0]       r_threshold;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic                     r_clr_op;
    logic                     r_res_query;

    // vote sequencer
    logic [PIXEL_X_W-1:0]     r_x;
    logic [PIXEL_Y_W-1:0]     r_y;
    logic [ANG_W-1:0]         r_m;
    logic [7:0]               r_deg;
    logic [ACC_W-1:0]         r_acc;
    logic                     r_rmw_valid;
    logic [ADDR_W-1:0]        r_rmw_addr;

    // query sequencer
    logic [DIST_IDX_W-1:0]    r_q_rho;
    logic [ANGLE_IDX_W-1:0]   r_q_ang;
    logic [ADDR_W-1:0]        r_base;
    logic                     r_interior;
    logic [3:0]               r_k;
    logic                     r_qv_valid;
    logic                     r_qv_first;
    logic [COUNT_W-1:0]       r_cur;
    logic                     r_beats_all;

    t_out_item                r_out_data;
    logic                     r_out_valid;

    logic [ACC_W-1:0]         n_acc_sum;
    logic [ADDR_W-1:0]        n_q_off;
    logic [ADDR_W-1:0]        n_q_addr;
    logic                     n_vote_ok;
    logic                     n_query_ok;

    logic                     rho_valid;
    logic [ADDR_W-1:0]        rho_addr;
    logic                     rho_busy;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [COUNT_W-1:0]       ram_wr_data;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [COUNT_W-1:0]       ram_rd_data;

    // Config beats are taken any cycle and land in the threshold at once.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Item checks done at accept time
    assign n_vote_ok  = (i_in_data.pixel_value == VOTE_PIXEL)
                     && (32'(i_in_data.pixel_x) < IMAGE_WIDTH)
                     && (32'(i_in_data.pixel_y) < IMAGE_HEIGHT);
    assign n_query_ok = (32'(i_in_data.angle_index) < ANGLE_BINS)
                     && (32'(i_in_data.distance_index) < RHO_BINS);

    // Degree of angle bin m is floor(m*180/ANGLE_BINS): advance by a whole step
    // and carry the remainder, so no divide is needed.
    assign n_acc_sum = r_acc + ACC_W'(DEG_REM);

    // Neighbor offsets: one distance row is ANGLE_BINS bins apart.
    always_comb begin
        unique case (r_k)
            RD_NW:   n_q_off = -STEP_AP1;
            RD_N:    n_q_off = -STEP_A;
            RD_NE:   n_q_off = -STEP_AM1;
            RD_W:    n_q_off = -STEP_1;
            RD_E:    n_q_off = STEP_1;
            RD_SW:   n_q_off = STEP_AM1;
            RD_S:    n_q_off = STEP_A;
            RD_SE:   n_q_off = STEP_AP1;
            default: n_q_off = '0;
        endcase
    end

    // Border bins read only the center, so neighbor addresses never leave the store
    assign n_q_addr = r_interior ? (r_base + n_q_off) : r_base;

    // Store ports: clearing owns the write port; queries own the read port in S_QREAD
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_we      = r_rmw_valid;
            ram_wr_addr = r_rmw_addr;
            ram_wr_data = (ram_rd_data == COUNT_MAX) ? COUNT_MAX : ram_rd_data + 1'b1;
        end
        ram_rd_addr = (r_state == S_QREAD) ? n_q_addr : rho_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_threshold <= THRESHOLD_RESET;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_res_query <= 1'b0;
            r_rmw_valid <= 1'b0;
            r_qv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end

            // Each angle's bin is read, then written back in the cycle after the read.
            r_rmw_valid <= rho_valid;
            r_rmw_addr  <= rho_addr;

            // Collect query read data: center first, then compare each neighbor.
            r_qv_valid <= (r_state == S_QREAD);
            if (r_qv_valid) begin
                if (r_qv_first) begin
                    r_cur <= ram_rd_data;
                end else if (ram_rd_data >= r_cur) begin
                    r_beats_all <= 1'b0;
                end
            end

            // Raise the result beat when one is ready, drop it once taken
            if (r_state == S_RESULT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_res_query <= 1'b0;
                        r_state     <= r_clr_op ? S_RESULT : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x         <= i_in_data.pixel_x;
                        r_y         <= i_in_data.pixel_y;
                        r_q_rho     <= i_in_data.distance_index;
                        r_q_ang     <= i_in_data.angle_index;
                        r_m         <= '0;
                        r_deg       <= '0;
                        r_acc       <= '0;
                        r_res_query <= (i_in_data.opcode == OP_QUERY) && n_query_ok;
                        unique case (i_in_data.opcode)
                            OP_VOTE: begin
                                r_state <= n_vote_ok ? S_VOTE : S_RESULT;
                            end
                            OP_QUERY: begin
                                r_state <= n_query_ok ? S_QBASE : S_RESULT;
                            end
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_op   <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_VOTE: begin
                    // One angle enters the rho pipeline per cycle
                    if (n_acc_sum >= ACC_W'(ANGLE_BINS)) begin
                        r_acc <= n_acc_sum - ACC_W'(ANGLE_BINS);
                        r_deg <= r_deg + 8'(DEG_STEP + 1);
                    end else begin
                        r_acc <= n_acc_sum;
                        r_deg <= r_deg + 8'(DEG_STEP);
                    end
                    if (r_m == ANG_W'(ANGLE_BINS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_m <= r_m + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // Hold until the last write-back has landed
                    if (!rho_busy && !r_rmw_valid) begin
                        r_state <= S_RESULT;
                    end
                end
                S_QBASE: begin
                    r_base      <= ADDR_W'(32'(r_q_rho) * ANGLE_BINS + 32'(r_q_ang));
                    r_interior  <= (r_q_rho != '0) && (32'(r_q_rho) < RHO_BINS - 1)
                                && (r_q_ang != '0) && (32'(r_q_ang) < ANGLE_BINS - 1);
                    r_k         <= RD_CENTER;
                    r_beats_all <= 1'b1;
                    r_state     <= S_QREAD;
                end
                S_QREAD: begin
                    r_qv_first <= (r_k == RD_CENTER);
                    if (r_k == RD_SE || !r_interior) begin
                        r_state <= S_QWAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_QWAIT: begin
                    // Last read data is folded in at this edge
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || i_out_ready) begin
                        if (r_res_query) begin
                            r_out_data.vote_count <= r_cur;
                            r_out_data.is_peak    <= r_interior && (r_cur > r_threshold)
                                                  && r_beats_all;
                        end else begin
                            r_out_data <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    hlva_rho_unit #(
        .ANGLE_BINS   (ANGLE_BINS),
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_rho_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == S_VOTE),
        .i_angle (r_m),
        .i_deg   (r_deg),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_valid (rho_valid),
        .o_addr  (rho_addr),
        .o_busy  (rho_busy)
    );

    hlva_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_vote_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

FILE: tb/hough_line_vote_accumulator_core_tb.sv
`timescale 1ns / 100ps

module hough_line_vote_accumulator_core_tb;
    import hlva_pkg::*;

    // Geometry of the block under test, kept at its defaults
    localparam int IMG_W    = 640;
    localparam int IMG_H    = 480;
    localparam int N_ANGLES = 180;
    localparam int MAX_DIST = 800;
    localparam int N_RHO    = 2 * MAX_DIST + 1;
    localparam int N_BINS   = N_ANGLES * N_RHO;
    localparam int IN_BITS  = $bits(t_in_item);

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    // A clear or the clearing pass after reset moves no beat until the store is zeroed
    localparam int IDLE_LIMIT   = 1_000_000;
    // Idle tail after the drain, so that stray result beats have a chance to show up
    localparam int TAIL_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 1900;
    localparam int N_PHASES     = 6;
    localparam int RECENT_DEPTH = 16;

    // Angle bins of the diagonal and anti-diagonal lines (one bin per degree)
    localparam int ANG_DIAG = DEG_QUARTER / 2;
    localparam int ANG_ANTI = DEG_QUARTER + DEG_QUARTER / 2;

    // Opcode with no function: returns an all-zero result
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    // Q1.14 sine of whole degrees 0..90
    localparam int QSIN [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef enum {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum {LINE_HORIZ, LINE_VERT, LINE_DIAG, LINE_ANTI} t_line_kind;

    typedef struct {
        t_row_kind          kind;
        t_in_item           item;
        logic [COUNT_W-1:0] cfg_value;
        bit                 typed;
        t_out_item          result;
    } t_stim_row;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in_item           in_data;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    // Shadow of the vote store and the threshold register
    bit [COUNT_W-1:0] vote_bins [N_BINS];
    bit [COUNT_W-1:0] peak_threshold = THRESHOLD_RESET;

    t_out_item expected_results [$];
    t_stim_row directed_rows [$];
    int        recent_x [$];
    int        recent_y [$];

    int fail_count     = 0;
    int idle_cycles    = 0;
    int random_work    = 0;
    int stall_left     = 0;
    bit steady_stretch = 1'b0;
    t_out_item want;

    hough_line_vote_accumulator_core #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H),
        .ANGLE_BINS   (N_ANGLES),
        .MAX_DISTANCE (MAX_DIST)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Offset distance bin that pixel (x, y) votes into at angle bin m
    function automatic int rho_bin(input int x, input int y, input int m);
        int     deg;
        int     c;
        int     s;
        longint v;
        longint r;
        deg = (m * DEG_HALF_TURN) / N_ANGLES;
        if (deg <= DEG_QUARTER) begin
            c = QSIN[DEG_QUARTER - deg];
            s = QSIN[deg];
        end else begin
            c = -QSIN[deg - DEG_QUARTER];
            s = QSIN[DEG_HALF_TURN - deg];
        end
        v = longint'(x) * c + longint'(y) * s;
        // Round half away from zero
        if (v >= 0) begin
            r = (v + Q_HALF) >>> Q_FRAC;
        end else begin
            r = -((-v + Q_HALF) >>> Q_FRAC);
        end
        return int'(r) + MAX_DIST;
    endfunction

    // Apply one accepted beat to the shadow store and return its result
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item        res;
        int               m;
        int               n;
        int               idx;
        int               ang;
        int               rho;
        int               dr;
        int               da;
        bit [COUNT_W-1:0] cur;
        bit               peak;
        res = '0;
        case (it.opcode)
            OP_VOTE: begin
                if (it.pixel_value == VOTE_PIXEL && it.pixel_x < IMG_W
                        && it.pixel_y < IMG_H) begin
                    for (m = 0; m < N_ANGLES; m++) begin
                        n = rho_bin(it.pixel_x, it.pixel_y, m);
                        if (n >= 0 && n < N_RHO) begin
                            idx = n * N_ANGLES + m;
                            // Saturate at full scale
                            if (vote_bins[idx] != COUNT_MAX) begin
                                vote_bins[idx] = vote_bins[idx] + 1'b1;
                            end
                        end
                    end
                end
            end
            OP_QUERY: begin
                ang = it.angle_index;
                rho = it.distance_index;
                if (ang < N_ANGLES && rho < N_RHO) begin
                    cur  = vote_bins[rho * N_ANGLES + ang];
                    // Border bins never qualify; inner bins must beat all eight neighbors
                    peak = cur > peak_threshold && rho > 0 && rho < N_RHO - 1
                        && ang > 0 && ang < N_ANGLES - 1;
                    if (peak) begin
                        for (dr = -1; dr <= 1; dr++) begin
                            for (da = -1; da <= 1; da++) begin
                                if (!(dr == 0 && da == 0)
                                        && cur <= vote_bins[(rho + dr) * N_ANGLES + ang + da]) begin
                                    peak = 1'b0;
                                end
                            end
                        end
                    end
                    res.vote_count = cur;
                    res.is_peak    = peak;
                end
            end
            OP_CLEAR: begin
                foreach (vote_bins[i]) begin
                    vote_bins[i] = '0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_stretch) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item vote_item(input int x, input int y);
        t_in_item it;
        it                = IN_BITS'({$urandom, $urandom});
        it.opcode         = OP_VOTE;
        it.pixel_x        = PIXEL_X_W'(x);
        it.pixel_y        = PIXEL_Y_W'(y);
        it.pixel_value    = VOTE_PIXEL;
        return it;
    endfunction

    function automatic t_in_item query_item(input int ang, input int rho);
        t_in_item it;
        it                = IN_BITS'({$urandom, $urandom});
        it.opcode         = OP_QUERY;
        it.angle_index    = ANGLE_IDX_W'(ang);
        it.distance_index = DIST_IDX_W'(rho);
        return it;
    endfunction

    function automatic t_stim_row item_row(input logic [OPCODE_W-1:0] op, input int x,
                                           input int y, input int pv, input int ang,
                                           input int rho, input bit typed, input int cnt,
                                           input bit pk);
        t_stim_row row;
        row.kind                = ROW_ITEM;
        row.item.opcode         = op;
        row.item.pixel_x        = PIXEL_X_W'(x);
        row.item.pixel_y        = PIXEL_Y_W'(y);
        row.item.pixel_value    = PIXEL_V_W'(pv);
        row.item.angle_index    = ANGLE_IDX_W'(ang);
        row.item.distance_index = DIST_IDX_W'(rho);
        row.cfg_value           = '0;
        row.typed               = typed;
        row.result.vote_count   = COUNT_W'(cnt);
        row.result.is_peak      = pk;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input int value);
        t_stim_row row;
        row           = item_row(OP_NOP, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0);
        row.kind      = ROW_CFG;
        row.cfg_value = COUNT_W'(value);
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input t_stim_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Present one input beat, hold it until accepted, then queue its expected result.
    // A typed result, where given, stands in for the predicted one.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        int        gap;
        t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_ready !== 1'b1);
        res = predict_result(it);
        expected_results.insert(expected_results.size(), typed ? typed_res : res);
    endtask

    // Random beats; only queries, clears and votes that touch the store count as work
    task automatic send_checked(input t_in_item it);
        send_item(it, 1'b0, '0);
        if (it.opcode == OP_QUERY || it.opcode == OP_CLEAR
                || (it.opcode == OP_VOTE && it.pixel_value == VOTE_PIXEL
                    && it.pixel_x < IMG_W && it.pixel_y < IMG_H)) begin
            random_work++;
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        peak_threshold = value;
        cfg_valid <= 1'b0;
    endtask

    // Vote a handful of collinear pixels, then query the line's bin and its neighbors.
    // All points share one distance bin at the line's angle, which builds real peaks;
    // vertical lines land in the first angle column and so test the border rule.
    task automatic run_line_burst();
        t_line_kind kind;
        int         n;
        int         k;
        int         p;
        int         x;
        int         y;
        int         lo;
        int         hi;
        int         ang;
        int         rho;
        kind = t_line_kind'($urandom_range(0, 3));
        n    = $urandom_range(3, 10);
        case (kind)
            LINE_HORIZ: begin
                p   = $urandom_range(0, IMG_H - 1);
                ang = DEG_QUARTER;
            end
            LINE_VERT: begin
                p   = $urandom_range(0, IMG_W - 1);
                ang = 0;
            end
            LINE_DIAG: begin
                p   = $urandom_range(0, IMG_W + IMG_H - 2);
                ang = ANG_DIAG;
            end
            default: begin
                // p is y - x here
                p   = int'($urandom_range(0, IMG_W + IMG_H - 2)) - (IMG_W - 1);
                ang = ANG_ANTI;
            end
        endcase
        for (k = 0; k < n; k++) begin
            case (kind)
                LINE_HORIZ: begin
                    x = $urandom_range(0, IMG_W - 1);
                    y = p;
                end
                LINE_VERT: begin
                    x = p;
                    y = $urandom_range(0, IMG_H - 1);
                end
                LINE_DIAG: begin
                    lo = (p > IMG_H - 1) ? p - (IMG_H - 1) : 0;
                    hi = (p < IMG_W - 1) ? p : IMG_W - 1;
                    x  = $urandom_range(lo, hi);
                    y  = p - x;
                end
                default: begin
                    lo = (p < 0) ? -p : 0;
                    hi = (IMG_H - 1 - p < IMG_W - 1) ? IMG_H - 1 - p : IMG_W - 1;
                    x  = $urandom_range(lo, hi);
                    y  = p + x;
                end
            endcase
            send_checked(vote_item(x, y));
            recent_x.insert(recent_x.size(), x);
            recent_y.insert(recent_y.size(), y);
            if (recent_x.size() > RECENT_DEPTH) begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end
        rho = rho_bin(x, y, ang);
        n   = $urandom_range(1, 4);
        // Hit the line's own bin first, then jitter around it
        send_checked(query_item(ang, rho));
        for (k = 0; k < n; k++) begin
            send_checked(query_item(ang + int'($urandom_range(0, 2)) - 1,
                                    rho + int'($urandom_range(0, 2)) - 1));
        end
    endtask

    // Check each result beat against the oldest expectation; pick the next ready
    always @(posedge clk) begin
        if (out_valid === 1'b1 && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: vote_count %0d is_peak %0d",
                       out_data.vote_count, out_data.is_peak);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_data.vote_count !== want.vote_count) begin
                    $error("vote_count: expected %0d, got %0d",
                           want.vote_count, out_data.vote_count);
                    fail_count++;
                end
                if (out_data.is_peak !== want.is_peak) begin
                    $error("is_peak: expected %0d, got %0d", want.is_peak, out_data.is_peak);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk) begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
                || (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int        ph;
        int        sel;
        int        i;
        int        rho;
        int        phase_thr [N_PHASES];
        t_in_item  it;
        t_stim_row row;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;

        // Directed table: after-reset reads, range edges, ignored votes, then a few
        // predicted reads around small counts, the border rule and a store clear
        add_row(item_row(OP_QUERY, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, N_ANGLES - 1, N_RHO - 1, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, N_ANGLES, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 1023, 511, 255, 255, 2047, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, 0, N_RHO, 1'b1, 0, 1'b0));
        add_row(item_row(OP_NOP, 1023, 511, 255, 255, 2047, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, 0, 0, 254, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, IMG_W, 0, 255, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, 0, IMG_H, 255, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, 1023, 511, 255, 255, 2047, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, 0, 0, 255, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, IMG_W - 1, IMG_H - 1, 255, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, DEG_QUARTER, MAX_DIST, 1'b0, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, 0, MAX_DIST, 1'b0, 0, 1'b0));
        add_row(cfg_row(0));
        add_row(item_row(OP_QUERY, 0, 0, 0, DEG_QUARTER, MAX_DIST, 1'b0, 0, 1'b0));
        add_row(item_row(OP_VOTE, 320, 240, 255, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_VOTE, 320, 240, 255, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, DEG_QUARTER, MAX_DIST + 240, 1'b0, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, 0, MAX_DIST + 320, 1'b0, 0, 1'b0));
        add_row(cfg_row(COUNT_MAX));
        add_row(item_row(OP_QUERY, 0, 0, 0, DEG_QUARTER, MAX_DIST + 240, 1'b0, 0, 1'b0));
        add_row(item_row(OP_CLEAR, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));
        add_row(item_row(OP_QUERY, 0, 0, 0, DEG_QUARTER, MAX_DIST + 240, 1'b1, 0, 1'b0));

        // Hold reset, then release it once; the block clears its store before taking beats
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                write_threshold(row.cfg_value);
            end else begin
                send_item(row.item, row.typed, row.result);
            end
        end

        // Random phases, each at its own threshold, extremes included
        phase_thr[0] = 0;
        phase_thr[1] = 1;
        phase_thr[2] = COUNT_MAX;
        phase_thr[3] = $urandom_range(2, 12);
        phase_thr[4] = 3;
        phase_thr[5] = THRESHOLD_RESET;

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_threshold(COUNT_W'(phase_thr[ph]));
            while (random_work < (ph + 1) * RANDOM_ITEMS / N_PHASES) begin
                // Now and then run a whole sequence with no idling on either side
                steady_stretch = ($urandom_range(0, 7) == 0);
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    run_line_burst();
                end else if (sel < 72 && recent_x.size() != 0) begin
                    // Read a bin that a recent pixel voted into, or a neighbor of it
                    i   = $urandom_range(0, recent_x.size() - 1);
                    sel = $urandom_range(0, N_ANGLES - 1);
                    rho = rho_bin(recent_x[i], recent_y[i], sel)
                        + int'($urandom_range(0, 2)) - 1;
                    send_checked(query_item(sel, rho));
                end else if (sel < 92) begin
                    // Noise: any field value; keep clears out, they cost a full pass
                    it = IN_BITS'({$urandom, $urandom});
                    case ($urandom_range(0, 2))
                        0:       it.opcode = OP_VOTE;
                        1:       it.opcode = OP_QUERY;
                        default: it.opcode = OP_NOP;
                    endcase
                    if ($urandom_range(0, 1) == 0) begin
                        it.pixel_value = VOTE_PIXEL;
                    end
                    send_checked(it);
                end else begin
                    send_checked(query_item($urandom_range(0, N_ANGLES - 1),
                                            $urandom_range(0, N_RHO - 1)));
                end
            end
        end
        steady_stretch = 1'b0;

        // Drain, then give stray beats a chance to show up
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: hough_line_vote_accumulator_core.f
rtl/hlva_pkg.sv
rtl/hlva_ram.sv
rtl/hlva_rho_unit.sv
rtl/hough_line_vote_accumulator_core.sv
tb/hough_line_vote_accumulator_core_tb.sv
